// File: rtl/gbp_pkg.sv
// Shared constants, types and codes for the gshare/BTB next-PC predictor.
// No dependencies; gshare_btb_branch_predictor imports this package.
`default_nettype none
package gbp_pkg;

  localparam int ADDR_W     = 64;
  localparam int BTB_IDX_W  = 10;
  localparam int HIST_W     = 8;
  localparam int CLR_W      = (BTB_IDX_W > HIST_W) ? BTB_IDX_W : HIST_W;
  localparam int CTR_W      = 2;

  localparam logic [CTR_W-1:0]  CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_MIN  = 2'd0;
  localparam logic [ADDR_W-1:0] INSN_LEN = 64'd4;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CTR_W-1:0]  ctr_t;

  typedef struct packed {
    logic  valid;
    logic  cond;
    addr_t tag;
    addr_t target;
  } btb_entry_t;

  localparam int BTB_ENTRY_W = $bits(btb_entry_t);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

endpackage
`default_nettype wire

// File: rtl/gbp_ram.sv
// Generic simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No package dependency.
`default_nettype none
module gbp_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/gshare_btb_branch_predictor.sv
// Top level: BTB memory, gshare counter memory, history and item control.
// Depends on gbp_pkg and gbp_ram.
// A predict item's result is registered at the end of its execute cycle, later
// while a stalled result still holds the output register.
// Items are handled one at a time (memory read, then execute).
// Reset: rst_n (synchronous) clears history and control, then a clearing
// pass over 2**CLR_W = 1024 addresses zeroes both memories; no item is accepted.
`default_nettype none
module gshare_btb_branch_predictor (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_action,
  input  wire gbp_pkg::addr_t in_pc,
  input  wire logic          in_is_conditional,
  input  wire logic          in_taken,
  input  wire gbp_pkg::addr_t in_target,
  output logic               out_valid,
  input  wire logic          out_stall,
  output gbp_pkg::addr_t     out_predicted_pc
);
  import gbp_pkg::*;

  // Control state. The block works on one item at a time: the accept edge
  // launches the reads of both memories, and the following execute cycle
  // forms the prediction or writes the update back.
  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic out_valid_r, out_valid_nxt;
  addr_t out_pc_r;

  // Captured item.
  logic  act_r, cond_r, taken_r;
  addr_t pc_r, tgt_r;

  logic accept;
  logic out_free;
  logic exec_done;
  logic load_out;

  // Memory ports.
  logic                 btb_we;
  logic [BTB_IDX_W-1:0] btb_waddr;
  btb_entry_t           btb_wdata;
  btb_entry_t           btb_rdata;
  logic                 pht_we;
  logic [HIST_W-1:0]    pht_waddr;
  ctr_t                 pht_wdata;
  ctr_t                 pht_rdata;

  logic [HIST_W-1:0]    pht_idx_exec;
  logic [HIST_W:0]      hist_shift;
  logic                 hit;
  logic                 use_target;
  addr_t                pred_pc;
  ctr_t                 ctr_upd;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // The output register frees up when empty or when its item leaves now,
  // so a new item may be taken while a result still waits downstream.
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_done = (act_r == ACT_UPDATE) || out_free;

  // Prediction. The tag compare and the sequential-address add run side by
  // side on the registered read data; the counter's upper bit says taken.
  assign hit        = btb_rdata.valid && (btb_rdata.tag == pc_r);
  assign use_target = hit && (!btb_rdata.cond || pht_rdata[CTR_W-1]);
  assign pred_pc    = use_target ? btb_rdata.target : (pc_r + INSN_LEN);

  // History has not moved since the read, so the same index is rebuilt.
  assign pht_idx_exec = pc_r[HIST_W+1:2] ^ hist_r;
  assign hist_shift   = {hist_r, taken_r};

  always_comb begin
    if (taken_r) begin
      ctr_upd = (pht_rdata == CTR_MAX) ? CTR_MAX : pht_rdata + 2'd1;
    end else begin
      ctr_upd = (pht_rdata == CTR_MIN) ? CTR_MIN : pht_rdata - 2'd1;
    end
  end

  assign load_out = (state_r == S_EXEC) && (act_r == ACT_PREDICT) && out_free;

  // Write-port steering: the clearing pass owns both ports after reset;
  // afterwards only an update item in its execute cycle writes.
  always_comb begin
    btb_we    = 1'b0;
    btb_waddr = pc_r[BTB_IDX_W+1:2];
    btb_wdata = {1'b1, cond_r, pc_r, tgt_r};
    pht_we    = 1'b0;
    pht_waddr = pht_idx_exec;
    pht_wdata = ctr_upd;
    unique case (state_r)
      S_CLEAR: begin
        btb_we    = 1'b1;
        btb_waddr = clr_cnt_r[BTB_IDX_W-1:0];
        btb_wdata = '0;
        pht_we    = 1'b1;
        pht_waddr = clr_cnt_r[HIST_W-1:0];
        pht_wdata = CTR_MIN;
      end
      S_EXEC: begin
        btb_we = (act_r == ACT_UPDATE);
        pht_we = (act_r == ACT_UPDATE) && cond_r;
      end
      S_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    hist_nxt      = hist_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {CLR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt = S_IDLE;
        end
        if ((act_r == ACT_UPDATE) && cond_r) begin
          hist_nxt = hist_shift[HIST_W-1:0];
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      pc_r    <= in_pc;
      cond_r  <= in_is_conditional;
      taken_r <= in_taken;
      tgt_r   <= in_target;
    end
    if (load_out) begin
      out_pc_r <= pred_pc;
    end
  end

  gbp_ram #(
    .WIDTH     (BTB_ENTRY_W),
    .ADDR_BITS (BTB_IDX_W)
  ) u_btb_ram (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .re    (accept),
    .raddr (in_pc[BTB_IDX_W+1:2]),
    .rdata (btb_rdata)
  );

  gbp_ram #(
    .WIDTH     (CTR_W),
    .ADDR_BITS (HIST_W)
  ) u_pht_ram (
    .clk   (clk),
    .we    (pht_we),
    .waddr (pht_waddr),
    .wdata (pht_wdata),
    .re    (accept),
    .raddr (in_pc[HIST_W+1:2] ^ hist_r),
    .rdata (pht_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_predicted_pc = out_pc_r;

endmodule
`default_nettype wire
